// ===== sv/srbp_pkg.sv =====
`default_nettype none

package srbp_pkg;

  localparam int TEMP_W = 16;
  localparam int ADC_W  = 10;
  localparam int ERR_W  = 2;
  localparam int VREF_W = 10;
  localparam int BCD_W  = 16;

  // Resolution of the supply converter; only the low ADC_BITS bits of a reading count.
  localparam int ADC_BITS = 10;

  localparam logic [VREF_W-1:0] VREF_RESET = VREF_W'(330);

  typedef struct packed {
    logic [TEMP_W-1:0] temp_word;
    logic [ADC_W-1:0]  adc_value;
    logic [ERR_W-1:0]  read_error;
  } srbp_in_t;

  typedef struct packed {
    logic [ERR_W-1:0] error_code;
    logic             negative_flag;
    logic [BCD_W-1:0] temp_bcd;
    logic [BCD_W-1:0] volt_bcd;
  } srbp_res_t;

endpackage

`default_nettype wire

// ===== sv/sensor_reading_bcd_packer.sv =====
// Sensor reading packer: turns one sample (temperature word, supply reading,
// read status) into a sign flag, a BCD temperature in tenths of a degree and a
// BCD supply voltage in hundredths of a volt, with the status passed along.
// Input channel: in_valid / in_stall with temp_word, adc_value, read_error.
// Output channel: out_valid / out_stall with error_code, negative_flag,
// temp_bcd, volt_bcd. A word moves when valid is high and stall is low.
// Configuration: cfg_valid / cfg_ready with cfg_data writes the converter
// reference in hundredths of a volt; cfg_ready is always high. Write it only
// while no sample is in flight.
// An accepted input word goes through one input register, the packing logic
// and one result register on its way to the output.
// Throughput is one word per cycle for as long as the output is not stalled.
// When the receiver stalls, the result register holds its word and the input
// register keeps one more; in_stall rises only once both are full.
// Reset (rst, synchronous) empties both registers and sets the reference to
// 330 hundredths of a volt.
`default_nettype none

module sensor_reading_bcd_packer (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire [srbp_pkg::TEMP_W-1:0]       temp_word,
  input  wire [srbp_pkg::ADC_W-1:0]        adc_value,
  input  wire [srbp_pkg::ERR_W-1:0]        read_error,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [srbp_pkg::ERR_W-1:0]       error_code,
  output logic                             negative_flag,
  output logic [srbp_pkg::BCD_W-1:0]       temp_bcd,
  output logic [srbp_pkg::BCD_W-1:0]       volt_bcd,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire [srbp_pkg::VREF_W-1:0]       cfg_data
);

  logic [srbp_pkg::VREF_W-1:0] vref;
  srbp_pkg::srbp_in_t          s1_item;
  logic                        s1_valid;
  logic                        s1_valid_next;
  logic                        out_valid_next;
  logic                        in_take;
  logic                        s1_move;
  srbp_pkg::srbp_res_t         res;
  srbp_pkg::srbp_res_t         out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vref <= srbp_pkg::VREF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      vref <= cfg_data;
    end
  end

  // The held word advances whenever the result register is empty or being taken.
  assign s1_move  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_next = s1_valid;
    if (in_take) begin
      s1_valid_next = 1'b1;
    end else if (s1_move) begin
      s1_valid_next = 1'b0;
    end

    out_valid_next = out_valid;
    if (s1_move) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= s1_valid_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item.temp_word  <= temp_word;
      s1_item.adc_value  <= adc_value;
      s1_item.read_error <= read_error;
    end
    if (s1_move) begin
      out_res <= res;
    end
  end

  srbp_calc u_calc (
    .item (s1_item),
    .vref (vref),
    .res  (res)
  );

  assign error_code    = out_res.error_code;
  assign negative_flag = out_res.negative_flag;
  assign temp_bcd      = out_res.temp_bcd;
  assign volt_bcd      = out_res.volt_bcd;

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && out_stall |=> s1_valid && out_valid)
    else $error("held word lost while output stalled");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !(out_valid && out_stall) |=> out_valid)
    else $error("held word did not reach the output");

  a_status: assert property (@(posedge clk) disable iff (rst)
    s1_move |=> error_code == $past(s1_item.read_error))
    else $error("status not carried to the result");

  a_digits: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> temp_bcd[3:0] == 4'd0 && temp_bcd[7:4] < 4'd10 &&
                  temp_bcd[11:8] < 4'd10 && volt_bcd[3:0] < 4'd10 &&
                  volt_bcd[7:4] < 4'd10 && volt_bcd[11:8] < 4'd10 &&
                  volt_bcd[15:12] < 4'd2)
    else $error("result digit out of BCD range");

endmodule

`default_nettype wire

// ===== sv/srbp_calc.sv =====
`default_nettype none

module srbp_calc (
  input  wire srbp_pkg::srbp_in_t             item,
  input  wire [srbp_pkg::VREF_W-1:0]          vref,
  output srbp_pkg::srbp_res_t                 res
);

  localparam int PROD_W = srbp_pkg::VREF_W + srbp_pkg::ADC_W + 1;
  localparam logic [srbp_pkg::ADC_W-1:0] ADC_MASK =
    srbp_pkg::ADC_W'((64'd1 << srbp_pkg::ADC_BITS) - 64'd1);
  localparam logic [PROD_W-1:0] ROUND_HALF =
    PROD_W'(64'd1 << (srbp_pkg::ADC_BITS - 1));

  logic [12:0]       raw;
  logic [12:0]       mag;
  logic [15:0]       scaled;
  logic [11:0]       t;
  logic [24:0]       t_mul10;
  logic [24:0]       t_mul100;
  logic [8:0]        t_div10;
  logic [5:0]        t_div100;
  logic [11:0]       t_tenths;
  logic [8:0]        t_units;

  logic [srbp_pkg::ADC_W-1:0] adc_used;
  logic [PROD_W-1:0] prod;
  logic [9:0]        v;
  logic [17:0]       v_mul10;
  logic [22:0]       v_mul100;
  logic [6:0]        v_div10;
  logic [3:0]        v_div100;
  logic              v_thou;
  logic [9:0]        v_ones;
  logic [6:0]        v_tens;
  logic [3:0]        v_hund;

  always_comb begin
    // Temperature: 13-bit count of 1/16 degree, rounded half up to tenths.
    raw    = item.temp_word[15:3];
    // Negating the most negative count gives 4096, which still fits 13 unsigned bits.
    mag    = raw[12] ? 13'(-raw) : raw;
    scaled = 16'(mag) * 16'd10 + 16'd8;
    t      = scaled[15:4];

    // Division by 10 and 100 through reciprocals, exact for t up to 2560.
    t_mul10  = 25'(t) * 25'd6554;
    t_mul100 = 25'(t) * 25'd5243;
    t_div10  = t_mul10[24:16];
    t_div100 = t_mul100[24:19];
    t_tenths = t - 12'(t_div10) * 12'd10;
    t_units  = t_div10 - 9'(t_div100) * 9'd10;

    // Voltage: stays below 1024 for every reference and reading.
    adc_used = item.adc_value & ADC_MASK;
    prod     = PROD_W'(vref) * PROD_W'(adc_used) + ROUND_HALF;
    v        = 10'(prod >> srbp_pkg::ADC_BITS);

    v_mul10  = 18'(v) * 18'd205;
    v_mul100 = 23'(v) * 23'd5243;
    v_div10  = v_mul10[17:11];
    v_div100 = v_mul100[22:19];
    v_thou   = (v >= 10'd1000);
    v_ones   = v - 10'(v_div10) * 10'd10;
    v_tens   = v_div10 - 7'(v_div100) * 7'd10;
    v_hund   = v_div100 - (v_thou ? 4'd10 : 4'd0);

    res.error_code    = item.read_error;
    res.negative_flag = raw[12];
    res.temp_bcd      = {t_div100[3:0], t_units[3:0], t_tenths[3:0], 4'd0};
    res.volt_bcd      = {3'd0, v_thou, v_hund, v_tens[3:0], v_ones[3:0]};
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 2000;
  localparam int PHASES = 8;
  localparam int PHASE_WORDS = 150;

  // One stimulus word plus, where it can be read off directly, its pinned result.
  typedef struct packed {
    srbp_pkg::srbp_in_t  stim;
    logic                pinned;
    srbp_pkg::srbp_res_t fixed;
  } row_t;

  logic                        clk;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [srbp_pkg::TEMP_W-1:0] temp_word = '0;
  logic [srbp_pkg::ADC_W-1:0]  adc_value = '0;
  logic [srbp_pkg::ERR_W-1:0]  read_error = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [srbp_pkg::ERR_W-1:0]  error_code;
  logic                        negative_flag;
  logic [srbp_pkg::BCD_W-1:0]  temp_bcd;
  logic [srbp_pkg::BCD_W-1:0]  volt_bcd;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [srbp_pkg::VREF_W-1:0] cfg_data = '0;

  row_t                        offered_rows[$];
  srbp_pkg::srbp_res_t         expected_packets[$];
  logic [srbp_pkg::VREF_W-1:0] vref_now = srbp_pkg::VREF_RESET;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_len = 0;

  sensor_reading_bcd_packer dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .temp_word     (temp_word),
    .adc_value     (adc_value),
    .read_error    (read_error),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .error_code    (error_code),
    .negative_flag (negative_flag),
    .temp_bcd      (temp_bcd),
    .volt_bcd      (volt_bcd),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic srbp_pkg::srbp_res_t pack_sample(
      input srbp_pkg::srbp_in_t s, input logic [srbp_pkg::VREF_W-1:0] vref);
    srbp_pkg::srbp_res_t r;
    logic [12:0] count;
    logic [12:0] mag;
    int unsigned adc;
    int unsigned tenths;
    int unsigned centi;
    count = s.temp_word[15:3];
    // Negating the most negative count wraps back to 0x1000, which is its magnitude.
    mag = count[12] ? (~count + 13'd1) : count;
    tenths = (32'(mag) * 10 + 8) >> 4;
    adc = 32'(s.adc_value) & ((32'd1 << srbp_pkg::ADC_BITS) - 1);
    centi = (32'(vref) * adc + (32'd1 << (srbp_pkg::ADC_BITS - 1))) >> srbp_pkg::ADC_BITS;
    r.error_code = s.read_error;
    r.negative_flag = count[12];
    r.temp_bcd = {4'(tenths / 100), 4'((tenths / 10) % 10), 4'(tenths % 10), 4'h0};
    r.volt_bcd = {4'(centi / 1000), 4'((centi / 100) % 10), 4'((centi / 10) % 10),
                  4'(centi % 10)};
    return r;
  endfunction

  function automatic row_t row(input logic [15:0] tw, input logic [9:0] adc,
                               input logic [1:0] err, input logic pinned,
                               input logic [1:0] ec, input logic neg,
                               input logic [15:0] tb, input logic [15:0] vb);
    row_t r;
    r.stim = {tw, adc, err};
    r.pinned = pinned;
    r.fixed = {ec, neg, tb, vb};
    return r;
  endfunction

  function automatic row_t random_row();
    row_t        r;
    int          deg16;
    logic [12:0] rim;
    r = '0;
    case ($urandom_range(0, 3))
      1: begin
        // Plausible sensor range, -40 to +125 degrees.
        deg16 = int'($urandom_range(0, 165 * 16)) - 40 * 16;
        r.stim.temp_word = {13'(deg16), 3'($urandom)};
      end
      2: begin
        case ($urandom_range(0, 5))
          0: rim = 13'h0FFF;
          1: rim = 13'h1000;
          2: rim = 13'h1001;
          3: rim = 13'h1FFF;
          4: rim = 13'h0000;
          default: rim = 13'h0001;
        endcase
        r.stim.temp_word = {rim, 3'($urandom)};
      end
      default: r.stim.temp_word = 16'($urandom);
    endcase
    if ($urandom_range(0, 7) == 0) begin
      r.stim.adc_value = $urandom_range(0, 1) ? 10'h3FF : 10'h000;
    end else begin
      r.stim.adc_value = 10'($urandom);
    end
    r.stim.read_error = $urandom_range(0, 1) ? 2'd0 : 2'($urandom);
    return r;
  endfunction

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      mismatches++;
    end
  endtask

  task automatic offer_word(input row_t r);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    offered_rows.push_back(r);
    in_valid <= 1'b1;
    temp_word <= r.stim.temp_word;
    adc_value <= r.stim.adc_value;
    read_error <= r.stim.read_error;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop offering and wait until every word in flight has come out.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_packets.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_vref(input logic [srbp_pkg::VREF_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        hold_left = hold_len;
        hold_len = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    srbp_pkg::srbp_res_t got;
    srbp_pkg::srbp_res_t want;
    row_t                r;
    logic                active;
    if (rst) begin
      vref_now = srbp_pkg::VREF_RESET;
      quiet_cycles = 0;
    end else begin
      active = 1'b0;
      if (out_valid && !out_stall) begin
        active = 1'b1;
        got = {error_code, negative_flag, temp_bcd, volt_bcd};
        if (expected_packets.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %h", $time, got);
          mismatches++;
        end else begin
          want = expected_packets.pop_front();
          check_field("error_code", want.error_code, got.error_code);
          check_field("negative_flag", want.negative_flag, got.negative_flag);
          check_field("temp_bcd", want.temp_bcd, got.temp_bcd);
          check_field("volt_bcd", want.volt_bcd, got.volt_bcd);
        end
      end
      if (cfg_valid && cfg_ready) begin
        active = 1'b1;
        vref_now = cfg_data;
      end
      if (in_valid && !in_stall) begin
        active = 1'b1;
        r = offered_rows.pop_front();
        if (r.pinned) begin
          expected_packets.push_back(r.fixed);
        end else begin
          expected_packets.push_back(pack_sample({temp_word, adc_value, read_error}, vref_now));
        end
      end
      quiet_cycles = active ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
        $display("sensor_reading_bcd_packer test failed");
        $finish;
      end
    end
  end

  initial begin
    row_t                        directed[$];
    logic [srbp_pkg::VREF_W-1:0] vref_plan[PHASES];

    vref_plan[0] = srbp_pkg::VREF_RESET;
    vref_plan[1] = 10'd1;
    vref_plan[2] = 10'd650;
    vref_plan[3] = 10'd0;
    vref_plan[4] = 10'd1023;
    vref_plan[5] = 10'($urandom_range(1, 650));
    vref_plan[6] = 10'($urandom_range(0, 1023));
    vref_plan[7] = srbp_pkg::VREF_RESET;

    // Directed words, all at the reset reference of 330.
    directed.push_back(row(16'h0000, 10'd0,    2'd0, 1'b1, 2'd0, 1'b0, 16'h0000, 16'h0000));
    directed.push_back(row(16'h7FF8, 10'd1023, 2'd0, 1'b1, 2'd0, 1'b0, 16'h9590, 16'h0330));
    // Most negative count: the top digit position wraps to 9.
    directed.push_back(row(16'h8000, 10'd0,    2'd3, 1'b1, 2'd3, 1'b1, 16'h9600, 16'h0000));
    directed.push_back(row(16'h8007, 10'd1023, 2'd1, 1'b1, 2'd1, 1'b1, 16'h9600, 16'h0330));
    directed.push_back(row(16'hFFF8, 10'd1,    2'd1, 1'b1, 2'd1, 1'b1, 16'h0010, 16'h0000));
    directed.push_back(row(16'h0007, 10'd512,  2'd2, 1'b1, 2'd2, 1'b0, 16'h0000, 16'h0165));
    directed.push_back(row(16'h0040, 10'd1023, 2'd0, 1'b1, 2'd0, 1'b0, 16'h0050, 16'h0330));
    directed.push_back(row(16'h0008, 10'd2,    2'd0, 1'b0, 2'd0, 1'b0, 16'h0, 16'h0));
    directed.push_back(row(16'h0018, 10'd3,    2'd1, 1'b0, 2'd0, 1'b0, 16'h0, 16'h0));
    directed.push_back(row(16'h0050, 10'h155,  2'd2, 1'b0, 2'd0, 1'b0, 16'h0, 16'h0));
    directed.push_back(row(16'h0C80, 10'h2AA,  2'd3, 1'b0, 2'd0, 1'b0, 16'h0, 16'h0));
    directed.push_back(row(16'hFB00, 10'd700,  2'd0, 1'b0, 2'd0, 1'b0, 16'h0, 16'h0));
    directed.push_back(row(16'hAAA8, 10'h3FE,  2'd1, 1'b0, 2'd0, 1'b0, 16'h0, 16'h0));
    directed.push_back(row(16'h5557, 10'h001,  2'd2, 1'b0, 2'd0, 1'b0, 16'h0, 16'h0));
    directed.push_back(row(16'h1FF8, 10'd511,  2'd3, 1'b0, 2'd0, 1'b0, 16'h0, 16'h0));
    directed.push_back(row(16'hE000, 10'd513,  2'd0, 1'b0, 2'd0, 1'b0, 16'h0, 16'h0));
    directed.push_back(row(16'h8008, 10'd100,  2'd1, 1'b0, 2'd0, 1'b0, 16'h0, 16'h0));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 18;
    recv_stall_pct = 18;
    foreach (directed[i]) offer_word(directed[i]);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) write_vref(vref_plan[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      for (int i = 0; i < PHASE_WORDS; i++) begin
        // The receiver holds off while the sender keeps going, so the block backs up.
        if (p == 0 && i == 40) hold_len = 60;
        if (p == 1 && i == 75) settle();
        offer_word(random_row());
      end
      settle();
    end

    if (mismatches == 0 && expected_packets.size() == 0) begin
      $display("sensor_reading_bcd_packer test passed");
    end else begin
      $display("sensor_reading_bcd_packer test failed");
    end
    $finish;
  end

endmodule

// ===== sensor_reading_bcd_packer.f =====
sv/srbp_pkg.sv
sv/srbp_calc.sv
sv/sensor_reading_bcd_packer.sv
tb/sv/tb.sv
